FILE: design/element_face_center_average_top_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for element_face_center_average_top
// Shared property forms for the port-level checker.
// ---------------------------------------------------------------------------
`ifndef ELEMENT_FACE_CENTER_AVERAGE_TOP_ASSERT_SVH
`define ELEMENT_FACE_CENTER_AVERAGE_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define EFCA_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("efca: same-cycle port check failed");

// The consequent must hold in the cycle after the antecedent.
`define EFCA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("efca: next-cycle port check failed");

`endif

FILE: design/efca_pkg.sv
// ---------------------------------------------------------------------------
// efca_pkg
// Types, face tables and helpers for the element face averaging block.
// ---------------------------------------------------------------------------
package efca_pkg;

	localparam int VALUE_WIDTH = 32;
	localparam int SUM_WIDTH   = VALUE_WIDTH + 2;
	localparam int NODE_COUNT  = 8;
	localparam int KIND_COUNT  = 6;
	localparam int MAX_FACES   = 6;
	localparam int FACE_NODES  = 4;
	localparam int DIV_STAGES  = (SUM_WIDTH + 7) / 8;
	localparam int PAD_WIDTH   = DIV_STAGES * 8;

	typedef logic signed [VALUE_WIDTH-1:0] value_t;
	typedef value_t [NODE_COUNT-1:0]        node_array_t;
	typedef logic signed [SUM_WIDTH-1:0]   sum_t;
	typedef logic [2:0]                    kind_t;
	typedef logic [2:0]                    node_idx_t;
	typedef logic [2:0]                    face_idx_t;
	typedef logic [1:0]                    div_code_t;

	localparam div_code_t DIV_2 = 2'd0;
	localparam div_code_t DIV_3 = 2'd1;
	localparam div_code_t DIV_4 = 2'd2;

	// Three times half the value range, so a biased three-node sum is never negative.
	localparam logic [SUM_WIDTH-1:0] DIV3_BIAS = {1'b0, 2'b11, {(VALUE_WIDTH-1){1'b0}}};
	localparam logic [VALUE_WIDTH-1:0] SIGN_FLIP = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

	localparam face_idx_t FACE_COUNT [KIND_COUNT] = '{3'd3, 3'd4, 3'd4, 3'd5, 3'd5, 3'd6};

	localparam div_code_t FACE_DIV [KIND_COUNT][MAX_FACES] = '{
		'{DIV_2, DIV_2, DIV_2, DIV_2, DIV_2, DIV_2},
		'{DIV_2, DIV_2, DIV_2, DIV_2, DIV_2, DIV_2},
		'{DIV_3, DIV_3, DIV_3, DIV_3, DIV_2, DIV_2},
		'{DIV_4, DIV_3, DIV_3, DIV_3, DIV_3, DIV_2},
		'{DIV_3, DIV_3, DIV_4, DIV_4, DIV_4, DIV_2},
		'{DIV_4, DIV_4, DIV_4, DIV_4, DIV_4, DIV_4}
	};

	localparam node_idx_t FACE_NODE [KIND_COUNT][MAX_FACES][FACE_NODES] = '{
		'{'{3'd0, 3'd1, 3'd0, 3'd0}, '{3'd1, 3'd2, 3'd0, 3'd0}, '{3'd2, 3'd0, 3'd0, 3'd0},
		  '{3'd0, 3'd0, 3'd0, 3'd0}, '{3'd0, 3'd0, 3'd0, 3'd0}, '{3'd0, 3'd0, 3'd0, 3'd0}},
		'{'{3'd0, 3'd1, 3'd0, 3'd0}, '{3'd1, 3'd2, 3'd0, 3'd0}, '{3'd2, 3'd3, 3'd0, 3'd0},
		  '{3'd3, 3'd0, 3'd0, 3'd0}, '{3'd0, 3'd0, 3'd0, 3'd0}, '{3'd0, 3'd0, 3'd0, 3'd0}},
		'{'{3'd0, 3'd1, 3'd2, 3'd0}, '{3'd0, 3'd1, 3'd3, 3'd0}, '{3'd1, 3'd2, 3'd3, 3'd0},
		  '{3'd0, 3'd2, 3'd3, 3'd0}, '{3'd0, 3'd0, 3'd0, 3'd0}, '{3'd0, 3'd0, 3'd0, 3'd0}},
		'{'{3'd0, 3'd1, 3'd2, 3'd3}, '{3'd0, 3'd1, 3'd4, 3'd0}, '{3'd1, 3'd2, 3'd4, 3'd0},
		  '{3'd2, 3'd3, 3'd4, 3'd0}, '{3'd3, 3'd0, 3'd4, 3'd0}, '{3'd0, 3'd0, 3'd0, 3'd0}},
		'{'{3'd0, 3'd1, 3'd2, 3'd0}, '{3'd3, 3'd4, 3'd5, 3'd0}, '{3'd0, 3'd1, 3'd4, 3'd3},
		  '{3'd1, 3'd2, 3'd5, 3'd4}, '{3'd2, 3'd0, 3'd3, 3'd5}, '{3'd0, 3'd0, 3'd0, 3'd0}},
		'{'{3'd0, 3'd1, 3'd2, 3'd3}, '{3'd4, 3'd5, 3'd6, 3'd7}, '{3'd3, 3'd0, 3'd4, 3'd7},
		  '{3'd1, 3'd2, 3'd6, 3'd5}, '{3'd0, 3'd1, 3'd5, 3'd4}, '{3'd2, 3'd3, 3'd7, 3'd6}}
	};

	typedef struct packed {
		logic      valid;
		sum_t      sum;
		div_code_t code;
		face_idx_t face;
		logic      last;
	} face_word_t;

	// Eight steps of long division by three; returns {remainder, quotient byte}.
	function automatic logic [9:0] div3_byte(input logic [1:0] rem, input logic [7:0] bits);
		logic [2:0] part;
		logic [1:0] r;
		logic [7:0] q;
		r = rem;
		q = '0;
		for (int i = 7; i >= 0; i--) begin
			part = {r, bits[i]};
			if (part >= 3'd3) begin
				q[i] = 1'b1;
				r = 2'(part - 3'd3);
			end else begin
				q[i] = 1'b0;
				r = part[1:0];
			end
		end
		return {r, q};
	endfunction

endpackage

FILE: design/efca_lane.sv
// ---------------------------------------------------------------------------
// efca_lane
// One face lane: gathers a face's nodes for the element kind and sums them.
// ---------------------------------------------------------------------------
module efca_lane (
	input  logic                   clk,
	input  logic                   load,
	input  efca_pkg::kind_t        kind,
	input  efca_pkg::face_idx_t    face,
	input  efca_pkg::node_array_t  nodes,
	output efca_pkg::sum_t         sum_s2,
	output efca_pkg::div_code_t    code_s2
);
	import efca_pkg::*;

	kind_t     kind_sel;
	div_code_t code;
	value_t    node0;
	value_t    node1;
	value_t    node2;
	value_t    node3;
	sum_t      pair_ab;
	sum_t      pair_cd;

	assign kind_sel = (kind < kind_t'(KIND_COUNT)) ? kind : '0;
	assign code     = FACE_DIV[kind_sel][face];
	assign node0    = nodes[FACE_NODE[kind_sel][face][0]];
	assign node1    = nodes[FACE_NODE[kind_sel][face][1]];
	assign node2    = (code != DIV_2) ? nodes[FACE_NODE[kind_sel][face][2]] : '0;
	assign node3    = (code == DIV_4) ? nodes[FACE_NODE[kind_sel][face][3]] : '0;
	assign pair_ab  = sum_t'(node0) + sum_t'(node1);
	assign pair_cd  = sum_t'(node2) + sum_t'(node3);

	always_ff @(posedge clk) begin
		if (load) begin
			sum_s2  <= pair_ab + pair_cd;
			code_s2 <= code;
		end
	end

endmodule

FILE: design/efca_merge.sv
// ---------------------------------------------------------------------------
// efca_merge
// Holds the lane sums of one element and sends one face word per cycle.
// ---------------------------------------------------------------------------
module efca_merge (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 load,
	input  efca_pkg::face_idx_t  face_total,
	input  efca_pkg::sum_t       lane_sum  [efca_pkg::MAX_FACES],
	input  efca_pkg::div_code_t  lane_code [efca_pkg::MAX_FACES],
	output logic                 take,
	output efca_pkg::face_word_t word
);
	import efca_pkg::*;

	logic      valid_q;
	face_idx_t count_q;
	face_idx_t total_q;
	logic      last;

	assign last = (count_q == (total_q - 3'd1));
	assign take = !valid_q || last;

	always_comb begin
		word.valid = valid_q;
		word.sum   = lane_sum[count_q];
		word.code  = lane_code[count_q];
		word.face  = count_q;
		word.last  = last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			count_q <= '0;
			total_q <= '0;
		end else if (load) begin
			valid_q <= (face_total != '0);
			count_q <= '0;
			total_q <= face_total;
		end else if (valid_q && last) begin
			valid_q <= 1'b0;
		end else if (valid_q) begin
			count_q <= count_q + 3'd1;
		end
	end

endmodule

FILE: design/efca_div.sv
// ---------------------------------------------------------------------------
// efca_div
// Floor division of a face sum by 2, 3 or 4, pipelined a byte per stage.
// ---------------------------------------------------------------------------
module efca_div (
	input  logic                 clk,
	input  logic                 arst_n,
	input  efca_pkg::face_word_t word,
	output logic                 strobe,
	output efca_pkg::value_t     face_value,
	output efca_pkg::face_idx_t  face_number,
	output logic                 last_face
);
	import efca_pkg::*;

	logic                   valid_s [DIV_STAGES+1];
	sum_t                   sum_s   [DIV_STAGES+1];
	div_code_t              code_s  [DIV_STAGES+1];
	face_idx_t              face_s  [DIV_STAGES+1];
	logic                   last_s  [DIV_STAGES+1];
	logic [PAD_WIDTH-1:0]   num_s   [DIV_STAGES+1];
	logic [PAD_WIDTH-1:0]   quot_s  [DIV_STAGES+1];
	logic [1:0]             rem_s   [DIV_STAGES+1];
	logic [9:0]             step    [DIV_STAGES];
	logic [SUM_WIDTH-1:0]   biased;
	sum_t                   half;
	sum_t                   quarter;
	value_t                 mean;
	logic                   strobe_q;
	logic                   last_q;
	value_t                 value_q;
	face_idx_t              number_q;

	assign biased = word.sum + DIV3_BIAS;

	always_comb begin
		for (int k = 0; k < DIV_STAGES; k++) begin
			step[k] = div3_byte(rem_s[k], num_s[k][PAD_WIDTH-1-8*k -: 8]);
		end
	end

	assign half    = sum_s[DIV_STAGES] >>> 1;
	assign quarter = sum_s[DIV_STAGES] >>> 2;

	always_comb begin
		case (code_s[DIV_STAGES])
			DIV_2:   mean = half[VALUE_WIDTH-1:0];
			DIV_3:   mean = quot_s[DIV_STAGES][VALUE_WIDTH-1:0] ^ SIGN_FLIP;
			DIV_4:   mean = quarter[VALUE_WIDTH-1:0];
			default: mean = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= DIV_STAGES; k++) begin
				valid_s[k] <= 1'b0;
			end
			strobe_q <= 1'b0;
			last_q   <= 1'b0;
		end else begin
			valid_s[0] <= word.valid;
			for (int k = 0; k < DIV_STAGES; k++) begin
				valid_s[k+1] <= valid_s[k];
			end
			strobe_q <= valid_s[DIV_STAGES];
			last_q   <= valid_s[DIV_STAGES] && last_s[DIV_STAGES];
		end
	end

	// Each stage fills only its own quotient byte; the lower bytes are still zero.
	always_ff @(posedge clk) begin
		sum_s[0]  <= word.sum;
		code_s[0] <= word.code;
		face_s[0] <= word.face;
		last_s[0] <= word.last;
		num_s[0]  <= PAD_WIDTH'(biased);
		quot_s[0] <= '0;
		rem_s[0]  <= '0;
		for (int k = 0; k < DIV_STAGES; k++) begin
			sum_s[k+1]  <= sum_s[k];
			code_s[k+1] <= code_s[k];
			face_s[k+1] <= face_s[k];
			last_s[k+1] <= last_s[k];
			num_s[k+1]  <= num_s[k];
			quot_s[k+1] <= quot_s[k] | (PAD_WIDTH'(step[k][7:0]) << (PAD_WIDTH - 8 - 8*k));
			rem_s[k+1]  <= step[k][9:8];
		end
		value_q  <= mean;
		number_q <= face_s[DIV_STAGES];
	end

	assign strobe      = strobe_q;
	assign last_face   = last_q;
	assign face_value  = value_q;
	assign face_number = number_q;

endmodule

FILE: design/element_face_center_average_top.sv
// ---------------------------------------------------------------------------
// element_face_center_average_top
// Node-to-face averaging for one mesh element per command.
// ---------------------------------------------------------------------------
// An element is taken at a clock edge with start high and busy low. Six face
// lanes sum every face of the element at once; the sums are then sent out one
// face per cycle, so an element holds the output side until all its faces are
// sent (3 to 6 faces; an unknown kind gives no word). The next element is
// taken while the current one is still being sent. Each result word is shown
// for exactly one cycle with strobe high, with last_face marking the element's
// final face; the first word of an element passes the input register, the lane
// sum registers, the merge counter and the byte-per-stage divide-by-three
// pipeline before the output register. Results cannot be held off.
module element_face_center_average_top (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  efca_pkg::kind_t      element_kind,
	input  efca_pkg::value_t     node_value_a,
	input  efca_pkg::value_t     node_value_b,
	input  efca_pkg::value_t     node_value_c,
	input  efca_pkg::value_t     node_value_d,
	input  efca_pkg::value_t     node_value_e,
	input  efca_pkg::value_t     node_value_f,
	input  efca_pkg::value_t     node_value_g,
	input  efca_pkg::value_t     node_value_h,
	output logic                 strobe,
	output efca_pkg::value_t     face_value,
	output efca_pkg::face_idx_t  face_number,
	output logic                 last_face
);
	import efca_pkg::*;

	logic        valid_s1;
	kind_t       kind_s1;
	node_array_t nodes_s1;
	logic        take;
	logic        advance;
	logic        accept;
	logic        kind_known;
	face_idx_t   face_total;
	sum_t        lane_sum  [MAX_FACES];
	div_code_t   lane_code [MAX_FACES];
	face_word_t  word;

	assign busy       = valid_s1 && !take;
	assign accept     = start && !busy;
	assign advance    = valid_s1 && take;
	assign kind_known = (kind_s1 < kind_t'(KIND_COUNT));
	assign face_total = kind_known ? FACE_COUNT[kind_s1] : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_s1  <= element_kind;
			nodes_s1 <= {node_value_h, node_value_g, node_value_f, node_value_e,
				node_value_d, node_value_c, node_value_b, node_value_a};
		end
	end

	for (genvar f = 0; f < MAX_FACES; f++) begin : g_lane
		efca_lane u_lane (
			.clk     (clk),
			.load    (advance),
			.kind    (kind_s1),
			.face    (face_idx_t'(f)),
			.nodes   (nodes_s1),
			.sum_s2  (lane_sum[f]),
			.code_s2 (lane_code[f])
		);
	end

	efca_merge u_merge (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (advance),
		.face_total (face_total),
		.lane_sum   (lane_sum),
		.lane_code  (lane_code),
		.take       (take),
		.word       (word)
	);

	efca_div u_div (
		.clk         (clk),
		.arst_n      (arst_n),
		.word        (word),
		.strobe      (strobe),
		.face_value  (face_value),
		.face_number (face_number),
		.last_face   (last_face)
	);

endmodule

FILE: design/efca_checker.sv
// ---------------------------------------------------------------------------
// efca_checker
// Port-level checks on the order of result words, bound to the top level.
// ---------------------------------------------------------------------------
`include "element_face_center_average_top_assert.svh"

module efca_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       strobe,
	input logic [2:0] face_number,
	input logic       last_face
);

	`EFCA_ASSERT_SAME(a_last_needs_strobe, clk, arst_n, last_face, strobe)
	`EFCA_ASSERT_NEXT(a_faces_back_to_back, clk, arst_n, strobe && !last_face, strobe && (face_number == $past(face_number) + 3'd1))
	`EFCA_ASSERT_SAME(a_element_starts_at_zero, clk, arst_n, strobe && ($past(last_face) || !$past(strobe)), face_number == 3'd0)

endmodule

bind element_face_center_average_top efca_checker u_efca_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.strobe      (strobe),
	.face_number (face_number),
	.last_face   (last_face)
);
